// ===== rtl/glmd_pkg.sv =====
// Shared constants for the grid local maximum detector.
package glmd_pkg;

    localparam int MAX_COLS_DEF   = 128;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int ROW_W          = 12;
    localparam int FRAME_COLS_W   = 8;

    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    // Register index, taken from paddr word address bit
    localparam logic REG_FRAME_ROWS = 1'b0;
    localparam logic REG_FRAME_COLS = 1'b1;

endpackage

// ===== rtl/glmd_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module glmd_ram #(
    parameter int WIDTH = glmd_pkg::PIXEL_BITS_DEF,
    parameter int DEPTH = glmd_pkg::MAX_COLS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem_reg[rd_addr_a];
        rd_data_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== rtl/grid_local_maximum_detector_top.sv =====
// Streaming strict 4-neighbour local maximum detector, top level.
//
// Usage:
//   Pixels of a frame enter on the item channel (item_valid/item_ready) in
//   row-major order, cmd 0. After the last row, frame_cols items with cmd 1
//   stand for the missing row below the frame. An item of the wrong kind for
//   the current phase is taken and dropped without a result.
//   Each verdict leaves on the result channel (result_valid/result_ready)
//   when the pixel below it (or the flush item of its column) is taken:
//   one row of items late, registered, valid in the cycle after that item.
//   Throughput is one item per cycle but for a stalled result; one line RAM
//   holds the two rows above as {two rows up, one row up} per column, read
//   at the current and next column, each read registered from col_next.
//   frame_rows and frame_cols are written over APB (addresses 0x0 and 0x4).
//   Reset clears the counters and the result valid flag and sets both frame
//   registers to 1; the line RAM is not cleared, and no row is judged from
//   entries the current frame has not written.
//   While a result waits and result_ready is low, item_ready is low too;
//   a taken result frees the stage in the same cycle.
module grid_local_maximum_detector_top #(
    parameter int MAX_COLS   = glmd_pkg::MAX_COLS_DEF,
    parameter int PIXEL_BITS = glmd_pkg::PIXEL_BITS_DEF,
    localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [glmd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [glmd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [glmd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,

    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic                            cmd,
    input  logic [PIXEL_BITS-1:0]           pixel,

    output logic                            result_valid,
    input  logic                            result_ready,
    output logic                            is_peak,
    output logic [PIXEL_BITS-1:0]           value,
    output logic [glmd_pkg::ROW_W-1:0]      row,
    output logic [ColW-1:0]                 col,
    output logic                            last
);

    localparam int RowW = glmd_pkg::ROW_W;
    localparam int FcW  = glmd_pkg::FRAME_COLS_W;
    localparam int CmpW = (ColW + 1 > FcW) ? ColW + 1 : FcW;
    localparam int EntW = 2 * PIXEL_BITS;

    // configuration
    logic [RowW-1:0] frame_rows_reg;
    logic [FcW-1:0]  frame_cols_reg;
    logic            cfg_write;

    // control state
    logic [RowW-1:0] row_reg, row_next, row_inc, rows_eff;
    logic [ColW-1:0] col_reg, col_next;
    logic            flushing_reg, flushing_next;

    logic            in_fire, step, row_end, has_result, peak;
    logic [ColW:0]   col_inc, rd_b_full;
    logic [CmpW-1:0] col_inc_cmp, cols_eff;
    logic [ColW-1:0] rd_addr_a, rd_addr_b;

    // line RAM and bypass
    logic [EntW-1:0]       rd_data_a, rd_data_b, a_entry, b_entry, wr_data;
    logic [EntW-1:0]       wr_data_reg;
    logic                  byp_a_reg, byp_b_reg;
    logic [PIXEL_BITS-1:0] center, a_two, b_one, px_eff, prev_center_reg;

    // result register
    logic                  result_valid_reg, result_valid_next;
    logic                  is_peak_reg, last_reg;
    logic [PIXEL_BITS-1:0] value_reg;
    logic [RowW-1:0]       row_out_reg;
    logic [ColW-1:0]       col_out_reg;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_rows_reg <= RowW'(1);
            frame_cols_reg <= FcW'(1);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                glmd_pkg::REG_FRAME_ROWS: frame_rows_reg <= pwdata[RowW-1:0];
                glmd_pkg::REG_FRAME_COLS: frame_cols_reg <= pwdata[FcW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            glmd_pkg::REG_FRAME_ROWS:
                prdata = glmd_pkg::APB_DATA_W'(frame_rows_reg);
            glmd_pkg::REG_FRAME_COLS:
                prdata = glmd_pkg::APB_DATA_W'(frame_cols_reg);
            default:
                prdata = '0;
        endcase
    end

    // ---------------- bounds ----------------
    always_comb
    begin
        if (frame_cols_reg == '0)
        begin
            cols_eff = CmpW'(1);
        end
        else if (CmpW'(frame_cols_reg) > CmpW'(MAX_COLS))
        begin
            cols_eff = CmpW'(MAX_COLS);
        end
        else
        begin
            cols_eff = CmpW'(frame_cols_reg);
        end
    end

    assign rows_eff    = (frame_rows_reg == '0) ? RowW'(1) : frame_rows_reg;
    assign col_inc     = (ColW + 1)'(col_reg) + (ColW + 1)'(1);
    assign col_inc_cmp = CmpW'(col_inc);
    assign row_end     = col_inc_cmp >= cols_eff;
    assign row_inc     = row_reg + RowW'(1);

    // ---------------- handshake ----------------
    assign item_ready = !result_valid_reg || result_ready;
    assign in_fire    = item_valid && item_ready;
    // drop items of the wrong kind for the current phase
    assign step       = in_fire && (cmd == flushing_reg);
    assign has_result = step && (row_reg != '0);

    // ---------------- counters ----------------
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        flushing_next = flushing_reg;
        if (step)
        begin
            if (!row_end)
            begin
                col_next = col_inc[ColW-1:0];
            end
            else if (flushing_reg)
            begin
                flushing_next = 1'b0;
                row_next      = '0;
                col_next      = '0;
            end
            else
            begin
                col_next = '0;
                row_next = row_inc;
                if (row_inc >= rows_eff)
                begin
                    flushing_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            flushing_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            flushing_reg <= flushing_next;
        end
    end

    // ---------------- line RAM ----------------
    // Read the entries of the column that comes next and of its right neighbour.
    assign rd_addr_a = col_next;
    assign rd_b_full = (ColW + 1)'(col_next) + (ColW + 1)'(1);
    assign rd_addr_b = (rd_b_full >= (ColW + 1)'(MAX_COLS)) ? ColW'(MAX_COLS - 1)
                                                             : rd_b_full[ColW-1:0];

    assign a_entry = byp_a_reg ? wr_data_reg : rd_data_a;
    assign b_entry = byp_b_reg ? wr_data_reg : rd_data_b;
    assign center  = a_entry[PIXEL_BITS-1:0];
    assign a_two   = a_entry[EntW-1:PIXEL_BITS];
    assign b_one   = b_entry[PIXEL_BITS-1:0];
    assign px_eff  = flushing_reg ? '0 : pixel;
    // shift the column down: one-up moves to two-up, new pixel to one-up
    assign wr_data = {center, px_eff};

    glmd_ram #(
        .WIDTH (EntW),
        .DEPTH (MAX_COLS)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (step),
        .wr_addr   (col_reg),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // forward a write that lands on the address being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_a_reg <= 1'b0;
            byp_b_reg <= 1'b0;
        end
        else
        begin
            byp_a_reg <= step && (col_reg == rd_addr_a);
            byp_b_reg <= step && (col_reg == rd_addr_b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            wr_data_reg     <= wr_data;
            prev_center_reg <= center;
        end
    end

    // ---------------- verdict ----------------
    always_comb
    begin
        peak = 1'b1;
        if (row_reg >= RowW'(2) && center <= a_two)
        begin
            peak = 1'b0;
        end
        if (!flushing_reg && center <= pixel)
        begin
            peak = 1'b0;
        end
        // left neighbour: center of the previous item in this row
        if (col_reg != '0 && center <= prev_center_reg)
        begin
            peak = 1'b0;
        end
        if (!row_end && center <= b_one)
        begin
            peak = 1'b0;
        end
    end

    // ---------------- result register ----------------
    always_comb
    begin
        if (has_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (has_result)
        begin
            is_peak_reg <= peak;
            value_reg   <= center;
            row_out_reg <= row_reg - RowW'(1);
            col_out_reg <= col_reg;
            last_reg    <= flushing_reg && row_end;
        end
    end

    assign result_valid = result_valid_reg;
    assign is_peak      = is_peak_reg;
    assign value        = value_reg;
    assign row          = row_out_reg;
    assign col          = col_out_reg;
    assign last         = last_reg;

`ifndef NO_ASSERTIONS
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ColW + 1)'(col_reg) < (ColW + 1)'(MAX_COLS))
        else $error("column counter beyond line RAM depth");

    a_flush_has_rows: assert property (@(posedge clk) disable iff (!rst_n)
        flushing_reg |-> (row_reg != '0))
        else $error("flush phase with row counter at zero");

    a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
        (step && flushing_reg && row_end) |=>
            (!flushing_reg && row_reg == '0 && col_reg == '0))
        else $error("frame did not restart after last flush item");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        has_result |=> (result_valid && last == $past(flushing_reg && row_end)))
        else $error("result not loaded for a judged pixel");
`endif

endmodule

// ===== test/tb_grid_local_maximum_detector_top.sv =====
// Self-checking testbench for the grid local maximum detector: directed table, random frames.
module tb_grid_local_maximum_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS = glmd_pkg::MAX_COLS_DEF;
    localparam int PIX_W    = glmd_pkg::PIXEL_BITS_DEF;
    localparam int ROW_W    = glmd_pkg::ROW_W;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = glmd_pkg::APB_ADDR_W;
    localparam int DATA_W   = glmd_pkg::APB_DATA_W;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int NOISE_PCT      = 8;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_ITEMS    = 60;

    typedef struct packed {
        logic             is_peak;
        logic [PIX_W-1:0] value;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } verdict_t;

    typedef enum logic [1:0] {STEP_ITEM, STEP_ROWS, STEP_COLS} step_kind_t;

    typedef struct packed {
        step_kind_t       kind;
        logic             c;
        logic [PIX_W-1:0] px;
        logic [11:0]      cfg;
        logic             typed;
        verdict_t         want;
    } dir_step_t;

    localparam verdict_t NO_VERDICT = '0;

    localparam dir_step_t DIR_TABLE [0:32] = '{
        // 1x1 frame after reset: always a peak
        '{STEP_ITEM, CMD_PIXEL, 8'hAB, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_FLUSH, 8'h00, 12'd0, 1'b1, '{1'b1, 8'hAB, 12'd0, 7'd0, 1'b1}},
        // flush while taking pixels: dropped
        '{STEP_ITEM, CMD_FLUSH, 8'hFF, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        // pixel while flushing: dropped
        '{STEP_ITEM, CMD_PIXEL, 8'hFF, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_FLUSH, 8'h00, 12'd0, 1'b1, '{1'b1, 8'h00, 12'd0, 7'd0, 1'b1}},
        // zero registers act as 1
        '{STEP_ROWS, CMD_PIXEL, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_COLS, CMD_PIXEL, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h55, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_FLUSH, 8'h00, 12'd0, 1'b1, '{1'b1, 8'h55, 12'd0, 7'd0, 1'b1}},
        // lower the row count once the counter has passed it
        '{STEP_ROWS, CMD_PIXEL, 8'h00, 12'd4, 1'b0, NO_VERDICT},
        '{STEP_COLS, CMD_PIXEL, 8'h00, 12'd3, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h07, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'hFF, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h07, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ROWS, CMD_PIXEL, 8'h00, 12'd1, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'hFE, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'hFF, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_FLUSH, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_FLUSH, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_FLUSH, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        // lower the column count in mid-row: the row ends at once
        '{STEP_ROWS, CMD_PIXEL, 8'h00, 12'd2, 1'b0, NO_VERDICT},
        '{STEP_COLS, CMD_PIXEL, 8'h00, 12'd4, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h01, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h02, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h03, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_COLS, CMD_PIXEL, 8'h00, 12'd2, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h04, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h09, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_PIXEL, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_FLUSH, 8'h00, 12'd0, 1'b0, NO_VERDICT},
        '{STEP_ITEM, CMD_FLUSH, 8'h00, 12'd0, 1'b0, NO_VERDICT}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid = 1'b0;
    logic              item_ready;
    logic              cmd = 1'b0;
    logic [PIX_W-1:0]  pixel = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              is_peak;
    logic [PIX_W-1:0]  value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              last;

    // Shadow of the detector state
    logic [11:0]      cfg_rows = 12'd1;
    logic [7:0]       cfg_cols = 8'd1;
    logic [PIX_W-1:0] line_up1 [MAX_COLS] = '{default: '0};
    logic [PIX_W-1:0] line_up2 [MAX_COLS] = '{default: '0};
    logic [ROW_W-1:0] row_cnt = '0;
    int               col_cnt = 0;
    bit               flush_mode = 1'b0;

    verdict_t verdict_q [$];
    int       err_cnt = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_tag = 0;
    int       seen_tag = 0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    grid_local_maximum_detector_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .cmd          (cmd),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_peak      (is_peak),
        .value        (value),
        .row          (row),
        .col          (col),
        .last         (last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the shadow state by one item; return 1 when a verdict is released
    function automatic bit predict_verdict(input logic c_in, input logic [PIX_W-1:0] px_in,
                                           output verdict_t v);
        int               rows;
        int               cols;
        int               k;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] center;
        bit               row_end;
        bit               peak;
        bit               got;
        rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
        cols = (cfg_cols == 0) ? 1 : ((cfg_cols > MAX_COLS) ? MAX_COLS : int'(cfg_cols));
        v = '0;
        got = 1'b0;
        if (c_in != flush_mode)
            return 1'b0;
        k = (col_cnt >= MAX_COLS) ? MAX_COLS - 1 : col_cnt;
        px = flush_mode ? '0 : px_in;
        row_end = (k + 1 >= cols);
        if (row_cnt >= 1)
        begin
            center = line_up1[k];
            peak = 1'b1;
            if (row_cnt >= 2 && center <= line_up2[k])
                peak = 1'b0;
            if (!flush_mode && center <= px)
                peak = 1'b0;
            if (k > 0 && center <= line_up2[k - 1])
                peak = 1'b0;
            if (k + 1 < cols && k + 1 < MAX_COLS && center <= line_up1[k + 1])
                peak = 1'b0;
            v.is_peak = peak;
            v.value   = center;
            v.row     = row_cnt - 1'b1;
            v.col     = k[COL_W-1:0];
            v.last    = flush_mode && row_end;
            got = 1'b1;
        end
        line_up2[k] = line_up1[k];
        line_up1[k] = px;
        if (!row_end)
            col_cnt = k + 1;
        else if (flush_mode)
        begin
            flush_mode = 1'b0;
            row_cnt = '0;
            col_cnt = 0;
        end
        else
        begin
            col_cnt = 0;
            row_cnt = row_cnt + 1'b1;
            if (row_cnt >= rows)
                flush_mode = 1'b1;
        end
        return got;
    endfunction

    task automatic send_item(input logic c_in, input logic [PIX_W-1:0] px_in,
                             input logic typed, input verdict_t typed_v);
        verdict_t v;
        bit       got;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= c_in;
        pixel      <= px_in;
        do
            @(posedge clk);
        while (!item_ready);
        got = predict_verdict(c_in, px_in, v);
        if (got)
            verdict_q.push_back(typed ? typed_v : v);
    endtask

    // Drop valid, drain every pending verdict, then let the pipeline settle
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] val);
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] stored;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == glmd_pkg::REG_FRAME_ROWS)
        begin
            cfg_rows = val[11:0];
            stored = {20'd0, val[11:0]};
        end
        else
        begin
            cfg_cols = val[7:0];
            stored = {24'd0, val[7:0]};
        end
        // read back the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== stored)
        begin
            $error("prdata[%0d]: expected %0d, actual %0d", idx, stored, rd);
            err_cnt++;
        end
    endtask

    // One frame at the current registers, with stray items of the wrong kind mixed in
    task automatic run_frame(output int good);
        int               rows;
        int               cols;
        int               mode;
        int               k;
        logic [PIX_W-1:0] px;
        rows = (cfg_rows == 0) ? 1 : int'(cfg_rows);
        cols = (cfg_cols == 0) ? 1 : ((cfg_cols > MAX_COLS) ? MAX_COLS : int'(cfg_cols));
        good = rows * cols + cols;
        mode = $urandom_range(0, 3);
        for (k = 0; k < good; k++)
        begin
            if ($urandom_range(0, 99) < NOISE_PCT)
                send_item(!flush_mode, PIX_W'($urandom_range(0, 255)), 1'b0, NO_VERDICT);
            case (mode)
                0: px = PIX_W'($urandom_range(0, 255));
                1: px = PIX_W'($urandom_range(0, 3));
                2: px = $urandom_range(0, 1) ? '1 : '0;
                default: px = PIX_W'($urandom_range(120, 136));
            endcase
            send_item(flush_mode, px, 1'b0, NO_VERDICT);
        end
    endtask

    // Check verdicts and drive result_ready
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result with nothing pending: row %0d col %0d value %0d", row, col, value);
                err_cnt++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (is_peak !== want.is_peak)
                begin
                    $error("is_peak: expected %0d, actual %0d", want.is_peak, is_peak);
                    err_cnt++;
                end
                if (value !== want.value)
                begin
                    $error("value: expected %0d, actual %0d", want.value, value);
                    err_cnt++;
                end
                if (row !== want.row)
                begin
                    $error("row: expected %0d, actual %0d", want.row, row);
                    err_cnt++;
                end
                if (col !== want.col)
                begin
                    $error("col: expected %0d, actual %0d", want.col, col);
                    err_cnt++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    err_cnt++;
                end
            end
        end
        if (seen_tag != hold_tag)
        begin
            seen_tag     <= hold_tag;
            hold_left    <= HOLD_CYCLES;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        int send_pcts [4];
        int recv_pcts [4];
        int ph;
        int taken;
        int good;
        int r;
        send_pcts = '{0, 60, 0, 35};
        recv_pcts = '{0, 0, 60, 35};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 35;
        recv_stall_pct = 35;
        for (int i = 0; i < $size(DIR_TABLE); i++)
        begin
            case (DIR_TABLE[i].kind)
                STEP_ROWS: write_reg(glmd_pkg::REG_FRAME_ROWS, DATA_W'(DIR_TABLE[i].cfg));
                STEP_COLS: write_reg(glmd_pkg::REG_FRAME_COLS, DATA_W'(DIR_TABLE[i].cfg));
                default:   send_item(DIR_TABLE[i].c, DIR_TABLE[i].px, DIR_TABLE[i].typed,
                                     DIR_TABLE[i].want);
            endcase
        end

        // Extreme frame shapes: tall and narrow, then wider than the line store
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        write_reg(glmd_pkg::REG_FRAME_ROWS, 32'd40);
        write_reg(glmd_pkg::REG_FRAME_COLS, 32'd1);
        run_frame(good);
        write_reg(glmd_pkg::REG_FRAME_ROWS, 32'd1);
        write_reg(glmd_pkg::REG_FRAME_COLS, 32'd255);
        run_frame(good);

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            taken = 0;
            while (taken < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 1))
                begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        write_reg(glmd_pkg::REG_FRAME_COLS, 32'd0);
                    else if (r < 60)
                        write_reg(glmd_pkg::REG_FRAME_COLS, $urandom_range(1, 12));
                    else if (r < 80)
                        write_reg(glmd_pkg::REG_FRAME_COLS, $urandom_range(13, 64));
                    else if (r < 90)
                        write_reg(glmd_pkg::REG_FRAME_COLS, $urandom_range(65, 128));
                    else
                        write_reg(glmd_pkg::REG_FRAME_COLS, $urandom_range(129, 255));
                end
                if ($urandom_range(0, 1) || cfg_cols > 32)
                begin
                    r = $urandom_range(0, 99);
                    // keep wide frames short
                    if (cfg_cols > 32)
                        write_reg(glmd_pkg::REG_FRAME_ROWS, $urandom_range(0, 1));
                    else if (r < 5)
                        write_reg(glmd_pkg::REG_FRAME_ROWS, 32'd0);
                    else if (r < 75)
                        write_reg(glmd_pkg::REG_FRAME_ROWS, $urandom_range(1, 6));
                    else
                        write_reg(glmd_pkg::REG_FRAME_ROWS, $urandom_range(7, 30));
                end
                // hold the receiver off for a long stretch while the frame is offered
                if (ph == 0 && taken == 0)
                    hold_tag = hold_tag + 1;
                run_frame(good);
                taken += good;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_cnt == 0 && verdict_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
